FILE: rtl/mbp_pkg.sv
// shared constants and types of the msb-first bit packer
package mbp_pkg;

    localparam int VALUE_W            = 64;
    localparam int COUNT_W            = 7;
    localparam int KIND_W             = 3;
    localparam int MAX_FIELD_BITS_DEF = 64;

    localparam logic [KIND_W-1:0] KIND_RAW   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BCD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SBCD  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SMAG  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ALIGN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FIN   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CLR   = 3'd7;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_WIDTH = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef struct packed {
        logic clear;
        logic shift;
        logic din;
    } t_conv_ctl;

endpackage

FILE: rtl/mbp_bcd_conv.sv
// bit-serial binary to bcd converter with sticky overflow
module mbp_bcd_conv #(
    parameter int DIGITS = mbp_pkg::MAX_FIELD_BITS_DEF / 4
) (
    input  logic                  i_clk,
    input  mbp_pkg::t_conv_ctl    i_ctl,
    output logic [4*DIGITS-1:0]   o_bcd,
    output logic                  o_ovf
);
    import mbp_pkg::*;

    localparam int BCD_W = 4 * DIGITS;

    logic [BCD_W-1:0] r_bcd, n_bcd, w_adj;
    logic             r_ovf, n_ovf;

    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int d = 0; d < DIGITS; d++) begin
            dig = r_bcd[4*d +: 4];
            w_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        n_ovf = r_ovf;
        if (i_ctl.clear) begin
            n_bcd = '0;
            n_ovf = 1'b0;
        end else if (i_ctl.shift) begin
            n_ovf = r_ovf | w_adj[BCD_W-1];
            n_bcd = {w_adj[BCD_W-2:0], i_ctl.din};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
        r_ovf <= n_ovf;
    end

    assign o_bcd = r_bcd;
    assign o_ovf = r_ovf;

endmodule

FILE: rtl/msb_first_bit_packer_bcd.sv
// msb-first bit packer with bcd, sign-magnitude and aligned integer fields
//
// s_axis takes one command word: tuser holds kind and byte order, tdata holds
// the operand and the field width. one command is worked at a time; tready is
// high only while no command is in progress.
// m_axis gives the packed stream one byte per word, tlast on the final word a
// command causes, tuser flags a real byte, frame end and the finish status.
// steps per command, from acceptance until ready again:
//   raw bits: one bit packed per cycle while the output register is free
//   sign-magnitude: a range check state, then the bits as for raw
//   bcd and signed bcd: the converter shifts all 64 operand bits, then range check and bits
//   aligned integer: a pad state, then one byte per cycle while the output register is free
//   byte align: pad state; finish: finish state; clear, bad width or a write in error: none
// a byte appears in the output register in the cycle after the bit that completes it
// reset empties the partial byte, clears the error and the output valid flag.
// while the receiver stalls, the steps that may emit a word halt and the held word
// stays unchanged; no byte is lost or duplicated.
module msb_first_bit_packer_bcd #(
    parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[63:0], count[70:64], zero fill
    input  logic [3:0]  s_axis_tuser,   // kind[2:0], big_endian[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast,
    output logic [3:0]  m_axis_tuser    // byte_valid[0], frame_end[1], status[3:2]
);
    import mbp_pkg::*;

    localparam int DIGITS = MAX_FIELD_BITS / 4;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int IDX_W  = $clog2(VALUE_W);
    localparam logic [COUNT_W-1:0] MAXC = COUNT_W'(MAX_FIELD_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_BITS  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_BYTES = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [7:0]         r_pend, n_pend;
    logic [2:0]         r_fill, n_fill;
    logic [1:0]         r_err, n_err;
    logic [VALUE_W-1:0] r_src, n_src;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [COUNT_W-1:0] r_lim, n_lim;
    logic [3:0]         r_nb, n_nb;
    logic               r_big, n_big;
    logic               r_sgn, n_sgn;
    logic               r_isbcd, n_isbcd;
    logic [IDX_W-1:0]   r_step, n_step;

    logic               r_ovalid;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_olast, n_olast;
    logic [3:0]         r_ouser, n_ouser;
    logic               n_emit;

    logic [KIND_W-1:0]  w_kind;
    logic [VALUE_W-1:0] w_value, w_mag;
    logic [COUNT_W-1:0] w_cnt;
    logic               w_neg, w_acc, w_free;
    logic [BCD_W-1:0]   w_bcd;
    logic               w_ovf;
    t_conv_ctl          w_ctl;

    assign w_kind  = s_axis_tuser[2:0];
    assign w_value = s_axis_tdata[VALUE_W-1:0];
    assign w_cnt   = s_axis_tdata[VALUE_W +: COUNT_W];
    assign w_neg   = w_value[VALUE_W-1];
    assign w_mag   = w_neg ? (~w_value + VALUE_W'(1)) : w_value;
    assign w_acc   = s_axis_tvalid & s_axis_tready;
    assign w_free  = ~r_ovalid | m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);

    mbp_bcd_conv #(
        .DIGITS(DIGITS)
    ) u_conv (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_bcd (w_bcd),
        .o_ovf (w_ovf)
    );

    always_comb begin
        logic             bad;
        logic             bit_in;
        logic [7:0]       pend;
        logic [IDX_W-1:0] idx;
        logic [2:0]       bi;

        bad     = 1'b0;
        bit_in  = 1'b0;
        pend    = r_pend;
        idx     = IDX_W'(r_left - COUNT_W'(1));
        bi      = 3'd0;

        n_state = r_state;
        n_pend  = r_pend;
        n_fill  = r_fill;
        n_err   = r_err;
        n_src   = r_src;
        n_left  = r_left;
        n_lim   = r_lim;
        n_nb    = r_nb;
        n_big   = r_big;
        n_sgn   = r_sgn;
        n_isbcd = r_isbcd;
        n_step  = r_step;
        n_emit  = 1'b0;
        n_obyte = 8'd0;
        n_olast = 1'b0;
        n_ouser = 4'd0;
        w_ctl   = '{clear: 1'b0, shift: 1'b0, din: r_src[VALUE_W-1]};

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_src   = w_value;
                    n_left  = w_cnt;
                    n_lim   = w_cnt - COUNT_W'(1);
                    n_sgn   = 1'b0;
                    n_isbcd = 1'b0;
                    n_big   = s_axis_tuser[3];
                    n_step  = IDX_W'(VALUE_W - 1);
                    if (w_kind == KIND_CLR) begin
                        n_pend = 8'd0;
                        n_fill = 3'd0;
                        n_err  = ERR_NONE;
                    end else if (w_kind == KIND_FIN) begin
                        n_state = ST_FIN;
                    end else if (r_err == ERR_NONE) begin
                        case (w_kind)
                            KIND_RAW: begin
                                if (w_cnt > MAXC) begin
                                    n_err = ERR_WIDTH;
                                end else if (w_cnt != '0) begin
                                    n_state = ST_BITS;
                                end
                            end
                            KIND_BCD: begin
                                if (w_cnt[1:0] != 2'd0 || w_cnt > MAXC) begin
                                    n_err = ERR_WIDTH;
                                end else if (w_cnt != '0) begin
                                    n_lim       = w_cnt;
                                    n_isbcd     = 1'b1;
                                    w_ctl.clear = 1'b1;
                                    n_state     = ST_CONV;
                                end
                            end
                            KIND_SBCD: begin
                                if (w_cnt < 7'd5 || w_cnt[1:0] != 2'd1 || w_cnt > 7'd61 ||
                                    w_cnt > MAXC) begin
                                    n_err = ERR_WIDTH;
                                end else begin
                                    n_src       = w_mag;
                                    n_sgn       = w_neg;
                                    n_isbcd     = 1'b1;
                                    w_ctl.clear = 1'b1;
                                    n_state     = ST_CONV;
                                end
                            end
                            KIND_SMAG: begin
                                if (w_cnt < 7'd2 || w_cnt > MAXC) begin
                                    n_err = ERR_WIDTH;
                                end else begin
                                    n_src   = w_mag;
                                    n_sgn   = w_neg;
                                    n_state = ST_CHK;
                                end
                            end
                            KIND_INT: begin
                                if (!(w_cnt inside {7'd8, 7'd16, 7'd32, 7'd64}) ||
                                    w_cnt > MAXC) begin
                                    n_err = ERR_WIDTH;
                                end else begin
                                    n_left  = COUNT_W'(w_cnt[COUNT_W-1:3]);
                                    n_nb    = w_cnt[COUNT_W-1:3];
                                    n_state = ST_PAD;
                                end
                            end
                            default: begin
                                n_left  = '0;
                                n_state = ST_PAD;
                            end
                        endcase
                    end
                end
            end
            ST_CONV: begin
                w_ctl.shift = 1'b1;
                n_src       = {r_src[VALUE_W-2:0], 1'b0};
                n_step      = r_step - IDX_W'(1);
                if (r_step == '0) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_isbcd) begin
                    bad = w_ovf;
                    for (int i = 0; i < BCD_W; i++) begin
                        if (w_bcd[i] && COUNT_W'(i) >= r_lim) begin
                            bad = 1'b1;
                        end
                    end
                    n_src = VALUE_W'(w_bcd);
                end else begin
                    for (int i = 0; i < VALUE_W; i++) begin
                        if (r_src[i] && COUNT_W'(i) >= r_lim) begin
                            bad = 1'b1;
                        end
                    end
                end
                if (bad) begin
                    n_err   = ERR_RANGE;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_BITS;
                end
            end
            ST_BITS: begin
                if (w_free) begin
                    bit_in = r_sgn | r_src[idx];
                    n_sgn  = 1'b0;
                    pend   = r_pend | (8'(bit_in) << (3'd7 - r_fill));
                    n_fill = r_fill + 3'd1;
                    n_pend = pend;
                    if (r_fill == 3'd7) begin
                        n_emit  = 1'b1;
                        n_obyte = pend;
                        n_olast = (r_left <= 7'd8);
                        n_ouser = 4'b0001;
                        n_pend  = 8'd0;
                    end
                    n_left = r_left - COUNT_W'(1);
                    if (r_left == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == 3'd0) begin
                    n_state = (r_left == '0) ? ST_IDLE : ST_BYTES;
                end else if (w_free) begin
                    n_emit  = 1'b1;
                    n_obyte = r_pend;
                    n_olast = (r_left == '0);
                    n_ouser = 4'b0001;
                    n_pend  = 8'd0;
                    n_fill  = 3'd0;
                    n_state = (r_left == '0) ? ST_IDLE : ST_BYTES;
                end
            end
            ST_BYTES: begin
                if (w_free) begin
                    bi      = r_big ? 3'(r_left - COUNT_W'(1)) : 3'(COUNT_W'(r_nb) - r_left);
                    n_emit  = 1'b1;
                    n_obyte = r_src[{bi, 3'b000} +: 8];
                    n_olast = (r_left == 7'd1);
                    n_ouser = 4'b0001;
                    n_left  = r_left - COUNT_W'(1);
                    if (r_left == 7'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (w_free) begin
                    n_emit  = 1'b1;
                    n_olast = 1'b1;
                    if (r_err == ERR_NONE && r_fill != 3'd0) begin
                        n_obyte = r_pend;
                        n_ouser = {r_err, 2'b11};
                    end else begin
                        n_ouser = {r_err, 2'b10};
                    end
                    n_pend  = 8'd0;
                    n_fill  = 3'd0;
                    n_err   = ERR_NONE;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend   <= 8'd0;
            r_fill   <= 3'd0;
            r_err    <= ERR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_fill  <= n_fill;
            r_err   <= n_err;
            if (n_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_left  <= n_left;
        r_lim   <= n_lim;
        r_nb    <= n_nb;
        r_big   <= n_big;
        r_sgn   <= n_sgn;
        r_isbcd <= n_isbcd;
        r_step  <= n_step;
        if (n_emit) begin
            r_obyte <= n_obyte;
            r_olast <= n_olast;
            r_ouser <= n_ouser;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    // a word without a real byte carries zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("empty word carries data");

    // frame end always closes the command
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("frame end without tlast");

    // status only reported on frame end
    a_status_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3:2] != 2'd0 |-> m_axis_tuser[1])
        else $error("status outside frame end");

    // partial byte holds while no command runs
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && !w_acc |=> $stable(r_fill) && $stable(r_pend))
        else $error("partial byte changed while idle");

endmodule
